>>> src/bavg_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bavg_pkg
// Shared constants and types for the box-average downscaler.
// -----------------------------------------------------------------------------
package bavg_pkg;
  localparam int MAX_SOURCE_WIDTH_D = 2048;
  localparam int MAX_TARGET_WIDTH_D = 1024;
  localparam int MAX_SCALE_D        = 16;

  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_TGT_W = 2'd2;
  localparam logic [1:0] REG_TGT_H = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic       start;    // begin a new pixel transaction (latch pixel)
    logic       rd;       // read accumulator entry
    logic       wr;       // write accumulator entry
    logic       div_go;   // start dividers
    logic       emit;     // load output register
  } bavg_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic out_busy;
  } bavg_sts_t;
endpackage
`default_nettype wire

>>> src/box_average_image_downscaler.sv
`default_nettype none
// -----------------------------------------------------------------------------
// box_average_image_downscaler
// Integer-ratio box-filter downscaler for 24-bit BGR raster streams.
// -----------------------------------------------------------------------------
// A pixel that falls in a dropped margin, or arrives while the ratio is
// invalid, is taken and dropped; any other pixel goes through a memory
// read, update and write of its accumulator entry. The last pixel of a block
// then starts the bit-serial dividers (SW = 16 bits at default MAX_SCALE) that
// form the three channel means, plus any wait for the output register to drain.
// After reset or any register write the ratios are computed by repeated
// subtraction (a load step, then subtraction steps), during which no pixel
// is taken. The accumulator memory is not cleared; each block's first pixel
// overwrites it.
module box_average_image_downscaler
  import bavg_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = MAX_SOURCE_WIDTH_D,
  parameter int MAX_TARGET_WIDTH = MAX_TARGET_WIDTH_D,
  parameter int MAX_SCALE        = MAX_SCALE_D
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // blue_in, green_in, red_in
  input  wire logic        in_tuser,   // frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // packed_color, out_column, out_row
  output logic             out_tlast,  // frame_done
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int RW = $clog2(MAX_SCALE*MAX_SCALE+1);
  localparam int AW = $clog2(MAX_TARGET_WIDTH);

  logic [11:0] sw_r, sh_r;
  logic [10:0] tw_r, th_r;
  logic        wr;
  bavg_cmd_t   cmd;
  bavg_sts_t   sts;
  logic        first, olast;
  logic [AW-1:0] col;
  logic [9:0]  ocol, orow;
  logic [RW-1:0] area;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= 12'd800; sh_r <= 12'd480; tw_r <= 11'd400; th_r <= 11'd240;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_paddr[3:2])
        REG_SRC_W: sw_r <= cfg_pwdata[11:0];
        REG_SRC_H: sh_r <= cfg_pwdata[11:0];
        REG_TGT_W: tw_r <= cfg_pwdata[10:0];
        REG_TGT_H: th_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_SRC_W: cfg_prdata = {20'b0, sw_r};
      REG_SRC_H: cfg_prdata = {20'b0, sh_r};
      REG_TGT_W: cfg_prdata = {21'b0, tw_r};
      REG_TGT_H: cfg_prdata = {21'b0, th_r};
      default:   cfg_prdata = '0;
    endcase
  end

  bavg_ctrl #(.MAX_SOURCE_WIDTH(MAX_SOURCE_WIDTH), .MAX_TARGET_WIDTH(MAX_TARGET_WIDTH),
    .MAX_SCALE(MAX_SCALE)) u_ctrl (
    .clk, .rst_n, .src_w(sw_r), .src_h(sh_r), .tgt_w(tw_r), .tgt_h(th_r),
    .cfg_wr(wr), .in_tvalid, .in_tready, .frame_start(in_tuser), .cmd, .sts,
    .first, .col, .ocol, .orow, .olast, .area);

  bavg_dp #(.MAX_TARGET_WIDTH(MAX_TARGET_WIDTH), .MAX_SCALE(MAX_SCALE)) u_dp (
    .clk, .rst_n, .cmd, .sts, .pix(in_tdata), .first, .col, .ocol, .orow,
    .olast, .area, .out_tvalid, .out_tready, .out_tdata, .out_tlast);
endmodule
`default_nettype wire

>>> src/bavg_div.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bavg_div
// Restoring divider, one quotient bit per cycle; quotient truncated to 8 bits.
// -----------------------------------------------------------------------------
module bavg_div #(
  parameter int NW = 20,
  parameter int DW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          go,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [7:0]         quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    if (go) begin
      q_nxt = num; rem_nxt = '0; d_nxt = den; cnt_nxt = CW'(NW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end

  assign done = done_r;
  assign quo  = q_r[7:0];
endmodule
`default_nettype wire

>>> src/bavg_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bavg_dp
// Datapath: column accumulator memory, three dividers, output register.
// -----------------------------------------------------------------------------
module bavg_dp #(
  parameter int MAX_TARGET_WIDTH = 1024,
  parameter int MAX_SCALE        = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bavg_pkg::bavg_cmd_t cmd,
  output bavg_pkg::bavg_sts_t    sts,
  input  wire logic [23:0]       pix,
  input  wire logic              first,     // first pixel of block: overwrite
  input  wire logic [$clog2(MAX_TARGET_WIDTH)-1:0] col,
  input  wire logic [9:0]        ocol,
  input  wire logic [9:0]        orow,
  input  wire logic              olast,
  input  wire logic [$clog2(MAX_SCALE*MAX_SCALE+1)-1:0] area,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [47:0]            out_tdata,
  output logic                   out_tlast
);
  import bavg_pkg::*;
  localparam int AW = $clog2(MAX_TARGET_WIDTH);
  localparam int SW = 8 + $clog2(MAX_SCALE*MAX_SCALE);
  localparam int RW = $clog2(MAX_SCALE*MAX_SCALE+1);

  logic [3*SW-1:0] mem [MAX_TARGET_WIDTH];
  logic [3*SW-1:0] rd_r, sum_r;
  logic [23:0]     pix_r;
  logic            first_r;
  logic [AW-1:0]   col_r;
  logic [9:0]      ocol_r, orow_r;
  logic            olast_r;
  logic [3*SW-1:0] sum_w;
  logic [2:0]      dn;
  logic [7:0]      q0, q1, q2;
  logic            ov_r, ov_nxt;
  logic [47:0]     od_r;
  logic            ol_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pix_r <= pix; first_r <= first; col_r <= col;
      ocol_r <= ocol; orow_r <= orow; olast_r <= olast;
    end
    if (cmd.rd) rd_r <= mem[col_r];
    if (cmd.wr) begin
      mem[col_r] <= sum_w;
      sum_r <= sum_w;
    end
  end

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_ch
      assign sum_w[g*SW +: SW] = first_r ? SW'(pix_r[g*8 +: 8])
                               : rd_r[g*SW +: SW] + SW'(pix_r[g*8 +: 8]);
    end
  endgenerate

  bavg_div #(.NW(SW), .DW(RW)) u_d0 (.clk, .rst_n, .go(cmd.div_go),
    .num(sum_r[0 +: SW]), .den(area), .done(dn[0]), .quo(q0));
  bavg_div #(.NW(SW), .DW(RW)) u_d1 (.clk, .rst_n, .go(cmd.div_go),
    .num(sum_r[SW +: SW]), .den(area), .done(dn[1]), .quo(q1));
  bavg_div #(.NW(SW), .DW(RW)) u_d2 (.clk, .rst_n, .go(cmd.div_go),
    .num(sum_r[2*SW +: SW]), .den(area), .done(dn[2]), .quo(q2));

  always_comb begin
    ov_nxt = ov_r;
    if (out_tvalid && out_tready) ov_nxt = 1'b0;
    if (cmd.emit) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= ov_nxt;
    if (cmd.emit) begin
      od_r <= {4'b0, orow_r, ocol_r, q2, q1, q0};
      ol_r <= olast_r;
    end
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = od_r;
  assign out_tlast    = ol_r;
  assign sts.div_done = &dn;
  assign sts.out_busy = ov_r && !out_tready;
endmodule
`default_nettype wire

>>> src/bavg_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bavg_ctrl
// Controller: ratio setup, position counters and transaction sequencing.
// -----------------------------------------------------------------------------
module bavg_ctrl #(
  parameter int MAX_SOURCE_WIDTH = 2048,
  parameter int MAX_TARGET_WIDTH = 1024,
  parameter int MAX_SCALE        = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [11:0] src_w,
  input  wire logic [11:0] src_h,
  input  wire logic [10:0] tgt_w,
  input  wire logic [10:0] tgt_h,
  input  wire logic        cfg_wr,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic        frame_start,
  output bavg_pkg::bavg_cmd_t cmd,
  input  wire bavg_pkg::bavg_sts_t sts,
  output logic             first,
  output logic [$clog2(MAX_TARGET_WIDTH)-1:0] col,
  output logic [9:0]       ocol,
  output logic [9:0]       orow,
  output logic             olast,
  output logic [$clog2(MAX_SCALE*MAX_SCALE+1)-1:0] area
);
  import bavg_pkg::*;
  localparam int RW = $clog2(MAX_SCALE*MAX_SCALE+1);
  localparam int AW = $clog2(MAX_TARGET_WIDTH);

  localparam logic [2:0] S_SETUP = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_WR = 3'd3,
                         S_DIVGO = 3'd4, S_DIV = 3'd5, S_EMIT = 3'd6;

  logic [2:0]  st_r, st_nxt;
  // ratio search by repeated subtraction
  logic [11:0] rx_rem_r, ry_rem_r;
  logic [12:0] rx_r, ry_r;
  logic        ld_r;              // load sizes on the first setup cycle
  logic        ok_r;
  logic [12:0] sc_r, ssr_r;       // source col / row counters
  logic [12:0] sub_c_r, sub_r_r;
  logic [11:0] blk_c_r, blk_r_r;
  logic [12:0] sc_n, ssr_n, subc_n, subr_n;
  logic [11:0] bc_n, br_n;
  logic        acc, inb, fire, fire_r;
  logic [12:0] ar;

  // setup: sizes loaded in the cycle after the write lands, then rx/ry by
  // subtraction, one step each per cycle
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      st_r <= S_SETUP;
      ld_r <= 1'b1;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_SETUP) begin
        if (ld_r) begin
          rx_rem_r <= src_w; ry_rem_r <= src_h; rx_r <= '0; ry_r <= '0;
          ld_r <= 1'b0;
        end else begin
          if (tgt_w != 0 && rx_rem_r >= 12'(tgt_w)) begin
            rx_rem_r <= rx_rem_r - 12'(tgt_w); rx_r <= rx_r + 1'b1;
          end
          if (tgt_h != 0 && ry_rem_r >= 12'(tgt_h)) begin
            ry_rem_r <= ry_rem_r - 12'(tgt_h); ry_r <= ry_r + 1'b1;
          end
        end
      end
    end
  end

  wire setup_done = !ld_r &&
                    (tgt_w == 0 || rx_rem_r < 12'(tgt_w)) &&
                    (tgt_h == 0 || ry_rem_r < 12'(tgt_h));
  always_comb
    ok_r = tgt_w != 0 && tgt_h != 0 && 32'(tgt_w) <= MAX_TARGET_WIDTH &&
           32'(src_w) <= MAX_SOURCE_WIDTH && rx_r != 0 && ry_r != 0 &&
           32'(rx_r) <= MAX_SCALE && ry_r != 0 && 32'(ry_r) <= MAX_SCALE;

  assign in_tready = (st_r == S_IDLE);
  assign acc = in_tvalid && in_tready;

  always_comb begin
    sc_n = sc_r; ssr_n = ssr_r; subc_n = sub_c_r; subr_n = sub_r_r;
    bc_n = blk_c_r; br_n = blk_r_r;
    if (frame_start) begin
      sc_n = '0; ssr_n = '0; subc_n = '0; subr_n = '0; bc_n = '0; br_n = '0;
    end
    inb  = 32'(bc_n) < 32'(tgt_w) && 32'(br_n) < 32'(tgt_h);
    first = subc_n == 0 && subr_n == 0;
    fire = inb && subc_n + 1 >= rx_r && subr_n + 1 >= ry_r;
    col  = AW'(bc_n);
    ocol = bc_n[9:0];
    orow = br_n[9:0];
    olast = 32'(bc_n) + 1 == 32'(tgt_w) && 32'(br_n) + 1 == 32'(tgt_h);
    if (32'(bc_n) < 32'(tgt_w)) begin
      subc_n = subc_n + 1'b1;
      if (subc_n >= rx_r) begin subc_n = '0; bc_n = bc_n + 1'b1; end
    end
    sc_n = sc_n + 1'b1;
    if (sc_n >= 13'(src_w)) begin
      sc_n = '0; subc_n = '0; bc_n = '0;
      if (32'(br_n) < 32'(tgt_h)) begin
        subr_n = subr_n + 1'b1;
        if (subr_n >= ry_r) begin subr_n = '0; br_n = br_n + 1'b1; end
      end
      ssr_n = ssr_n + 1'b1;
      if (ssr_n >= 13'(src_h)) begin
        sc_n = '0; ssr_n = '0; subc_n = '0; subr_n = '0; bc_n = '0; br_n = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r <= '0; ssr_r <= '0; sub_c_r <= '0; sub_r_r <= '0;
      blk_c_r <= '0; blk_r_r <= '0; fire_r <= 1'b0;
    end else if (acc && ok_r) begin
      sc_r <= sc_n; ssr_r <= ssr_n; sub_c_r <= subc_n; sub_r_r <= subr_n;
      blk_c_r <= bc_n; blk_r_r <= br_n; fire_r <= fire;
    end else if (acc && frame_start) begin
      sc_r <= '0; ssr_r <= '0; sub_c_r <= '0; sub_r_r <= '0;
      blk_c_r <= '0; blk_r_r <= '0;
    end
  end

  // inb gate carried into the sequence
  logic inb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) inb_r <= 1'b0;
    else if (acc) inb_r <= inb && ok_r;
  end

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    cmd.start = acc;
    case (st_r)
      S_SETUP: if (setup_done) st_nxt = S_IDLE;
      S_IDLE:  if (acc && ok_r && inb) st_nxt = S_RD;
      S_RD:    begin cmd.rd = 1'b1; st_nxt = S_WR; end
      S_WR:    begin cmd.wr = inb_r; st_nxt = fire_r ? S_DIVGO : S_IDLE; end
      S_DIVGO: begin cmd.div_go = 1'b1; st_nxt = S_DIV; end
      S_DIV:   if (sts.div_done) st_nxt = S_EMIT;
      S_EMIT:  if (!sts.out_busy) begin cmd.emit = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign ar   = rx_r * ry_r;
  assign area = RW'(ar);

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RD) |-> !in_tready) else $error("accept while busy");
  a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> $past(st_r) == S_DIV || $past(st_r) == S_EMIT)
    else $error("emit out of sequence");
  a_wr_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> $past(cmd.rd)) else $error("write without read");
`endif
endmodule
`default_nettype wire
